[design/svf_pkg.sv]
// Shared types and constants of the state variable filter.
package svf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 15;
  localparam int COEF_FRAC  = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;

  localparam logic [COEF_W-1:0] CUTOFF_RESET  = 15'd8192;
  localparam logic [COEF_W-1:0] DAMPING_RESET = 15'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_F,
    ST_MUL_Q,
    ST_HIGH,
    ST_MUL_H,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic mul_src_high;
    logic mul_coef_q;
    logic load_low;
    logic load_high;
    logic load_update;
  } ctrl_t;

endpackage

[design/svf_mul.sv]
// Shared coefficient multiplier with round half up and a registered product.
module svf_mul #(
  parameter int STATE_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [STATE_WIDTH-1:0]       operand,
  input  logic [svf_pkg::COEF_W-1:0]          coef,
  output logic signed [STATE_WIDTH+1:0]       prod
);

  localparam int PW = STATE_WIDTH + svf_pkg::COEF_W + 1;
  localparam logic signed [PW-1:0] RND = PW'(1) << (svf_pkg::COEF_FRAC - 1);

  logic signed [svf_pkg::COEF_W:0] coef_s;
  logic signed [PW-1:0]            full;
  logic signed [PW-1:0]            shifted;

  assign coef_s  = $signed({1'b0, coef});
  assign full    = PW'(operand) * PW'(coef_s) + RND;
  assign shifted = full >>> svf_pkg::COEF_FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= shifted[STATE_WIDTH+1:0];
    end
  end

endmodule

[design/svf_seq.sv]
// Sequencer that steps one sample through the shared multiplier.
module svf_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_valid,
  input  logic           out_ready,
  output logic           in_ready,
  output svf_pkg::ctrl_t ctrl
);

  svf_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      svf_pkg::ST_IDLE:   if (in_valid) state_next = svf_pkg::ST_MUL_F;
      svf_pkg::ST_MUL_F:  state_next = svf_pkg::ST_MUL_Q;
      svf_pkg::ST_MUL_Q:  state_next = svf_pkg::ST_HIGH;
      svf_pkg::ST_HIGH:   state_next = svf_pkg::ST_MUL_H;
      svf_pkg::ST_MUL_H:  state_next = svf_pkg::ST_UPDATE;
      svf_pkg::ST_UPDATE: if (out_free) state_next = svf_pkg::ST_IDLE;
      default:            state_next = svf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    case (state)
      svf_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.load_in = in_valid;
      end
      svf_pkg::ST_MUL_F: begin
        ctrl.mul_en = 1'b1;
      end
      svf_pkg::ST_MUL_Q: begin
        ctrl.mul_en     = 1'b1;
        ctrl.mul_coef_q = 1'b1;
        ctrl.load_low   = 1'b1;
      end
      svf_pkg::ST_HIGH: begin
        ctrl.load_high = 1'b1;
      end
      svf_pkg::ST_MUL_H: begin
        ctrl.mul_en       = 1'b1;
        ctrl.mul_src_high = 1'b1;
      end
      svf_pkg::ST_UPDATE: begin
        ctrl.load_update = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[design/state_variable_filter_unit.sv]
// Top level of the two-integrator state variable filter.
//
// Input channel: sample_in with in_valid / in_ready, one signed Q1.15 sample per beat.
// Output channel: high_out, band_out, low_out with out_valid / out_ready, one beat
// per input beat, in order.
// Configuration: cfg_we, cfg_index, cfg_data write cutoff_coeff (index 0) or
// damping (index 1), Q1.14 unsigned; other indexes are ignored. Write only while idle.
// Each sample makes three passes through one shared state-by-coefficient multiplier
// under a six-state sequencer. The result beat shows out_valid in the same cycle
// that in_ready returns high, so a new sample is taken only after the last one
// has been worked through.
// The output register holds a finished beat while the receiver stalls; the next
// sample is still accepted and worked, and its update waits until the held beat
// is taken.
// Reset clears both integrators and the output valid, and loads the coefficients
// with 0.5 and 1.0.
module state_variable_filter_unit #(
  parameter int STATE_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [svf_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [svf_pkg::SAMPLE_W-1:0]  high_out,
  output logic signed [svf_pkg::SAMPLE_W-1:0]  band_out,
  output logic signed [svf_pkg::SAMPLE_W-1:0]  low_out,
  input  logic                                 cfg_we,
  input  logic [svf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [svf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SW  = STATE_WIDTH;
  localparam int XSH = SW - 17;
  localparam int SWW = SW + 3;

  localparam logic signed [SWW-1:0] ST_MAX = {4'b0000, {(SW-1){1'b1}}};
  localparam logic signed [SWW-1:0] ST_MIN = {4'b1111, {(SW-1){1'b0}}};
  localparam logic signed [SW:0]    Q_MAX  = (SW+1)'(32767);
  localparam logic signed [SW:0]    Q_MIN  = ~Q_MAX;
  localparam logic signed [SW:0]    Q_RND  = (SW+1)'(1) << (XSH - 1);

  function automatic logic signed [SW-1:0] sat_state(input logic signed [SWW-1:0] v);
    logic signed [SWW-1:0] r;
    r = v;
    if (v > ST_MAX) r = ST_MAX;
    if (v < ST_MIN) r = ST_MIN;
    return r[SW-1:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [SW-1:0] v);
    logic signed [SW:0] r;
    r = ((SW+1)'(v) + Q_RND) >>> XSH;
    if (r > Q_MAX) r = Q_MAX;
    if (r < Q_MIN) r = Q_MIN;
    return r[15:0];
  endfunction

  svf_pkg::ctrl_t ctrl;

  logic [svf_pkg::COEF_W-1:0]         cutoff_coeff;
  logic [svf_pkg::COEF_W-1:0]         damping;
  logic signed [svf_pkg::SAMPLE_W-1:0] x;
  logic signed [SW-1:0]               low_int;
  logic signed [SW-1:0]               band_int;
  logic signed [SW-1:0]               low_val;
  logic signed [SW-1:0]               high_val;
  logic signed [SW+1:0]               prod;
  logic signed [SW-1:0]               mul_op;
  logic [svf_pkg::COEF_W-1:0]         mul_coef;
  logic signed [SW-1:0]               xs;
  logic signed [SW-1:0]               low_next;
  logic signed [SW-1:0]               high_next;
  logic signed [SW-1:0]               band_next;

  svf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  assign mul_op   = ctrl.mul_src_high ? high_val : band_int;
  assign mul_coef = ctrl.mul_coef_q ? damping : cutoff_coeff;

  svf_mul #(
    .STATE_WIDTH (SW)
  ) u_mul (
    .clk     (clk),
    .en      (ctrl.mul_en),
    .operand (mul_op),
    .coef    (mul_coef),
    .prod    (prod)
  );

  assign xs        = SW'($signed({x, {XSH{1'b0}}}));
  assign low_next  = sat_state(SWW'(low_int) + SWW'(prod));
  assign high_next = sat_state(SWW'(xs) - SWW'(prod) - SWW'(low_val));
  assign band_next = sat_state(SWW'(band_int) + SWW'(prod));

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_coeff <= svf_pkg::CUTOFF_RESET;
      damping      <= svf_pkg::DAMPING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        svf_pkg::REG_CUTOFF:  cutoff_coeff <= cfg_data;
        svf_pkg::REG_DAMPING: damping      <= cfg_data;
        default:              cutoff_coeff <= cutoff_coeff;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_int  <= '0;
      band_int <= '0;
    end else if (ctrl.load_update) begin
      low_int  <= low_val;
      band_int <= band_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      x <= sample_in;
    end
    if (ctrl.load_low) begin
      low_val <= low_next;
    end
    if (ctrl.load_high) begin
      high_val <= high_next;
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_update) begin
      high_out <= to_q15(high_val);
      band_out <= to_q15(band_int);
      low_out  <= to_q15(low_val);
    end
  end

endmodule

[design/svf_checker.sv]
// Port-level checks of the state variable filter and their binding.
module svf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] high_out,
  input logic [15:0] band_out,
  input logic [15:0] low_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(high_out) && $stable(band_out)
      && $stable(low_out))
    else $error("result beat dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
      ##1 !in_ready)
    else $error("sample accepted while the sequencer is busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared before the sequencer returned to idle");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the block");

endmodule

bind state_variable_filter_unit svf_checker u_svf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .high_out  (high_out),
  .band_out  (band_out),
  .low_out   (low_out)
);
